// File: sv/refcounted_handle_table_defines.svh
// Assertion macros for the refcounted handle table.
`ifndef REFCOUNTED_HANDLE_TABLE_DEFINES_SVH
`define REFCOUNTED_HANDLE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, reset-qualified.
`define RHT_ASSERT_IMPL(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rht: same-cycle implication failed");

// Next-cycle implication, reset-qualified.
`define RHT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rht: next-cycle implication failed");

`else

`define RHT_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define RHT_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

// File: sv/rht_pkg.sv
// Shared constants, codes and structs for the refcounted handle table.
package rht_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int SLOT_W        = 6;
	localparam int DEV_W         = 8;
	localparam int OBJ_W         = 16;
	localparam int LINK_W        = 16;
	localparam int REF_W         = 8;
	localparam int STATUS_W      = 3;

	// Only entries a slot number can reach are built.
	localparam int SLOT_REACH = 1 << SLOT_W;
	localparam int NCELL      = (TABLE_ENTRIES < SLOT_REACH) ? TABLE_ENTRIES : SLOT_REACH;
	localparam int CELL_W     = $clog2(NCELL);

	localparam logic [REF_W-1:0] REF_MAX = '1;

	typedef enum logic [1:0] {
		ACT_GET     = 2'd0,
		ACT_RETAIN  = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_LINKS   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_CLAIMED   = 3'd1,
		STS_FULL      = 3'd2,
		STS_SATURATED = 3'd3,
		STS_UNREF     = 3'd4
	} status_t;

	// Search token walking the cell row.
	typedef struct packed {
		logic               vld;
		action_t            act;
		logic [DEV_W-1:0]   dev;
		logic [OBJ_W-1:0]   obj;
		logic [SLOT_W-1:0]  slot;
		logic [LINK_W-1:0]  links;
		logic               hit;      // key match (get) or slot found (others)
		logic [CELL_W-1:0]  hit_idx;
		logic [REF_W-1:0]   refs;     // counters of the hit entry
		logic               valid;
		logic               lz;       // hit entry has zero links
		logic               free;
		logic [CELL_W-1:0]  free_idx;
	} tok_t;

	// Broadcast entry update.
	typedef struct packed {
		logic               en;
		logic [CELL_W-1:0]  idx;
		logic               wr_key;
		logic [DEV_W-1:0]   dev;
		logic [OBJ_W-1:0]   obj;
		logic [REF_W-1:0]   refs;
		logic               wr_valid;
		logic               valid;
		logic               wr_links;
		logic [LINK_W-1:0]  links;
	} wr_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		status_t            status;
		logic               fod;
		logic [REF_W-1:0]   refs;
	} rsp_t;

endpackage

// File: sv/rht_req_if.sv
// Request channel: action, key, slot and link count.
interface rht_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 action;
	logic [rht_pkg::DEV_W-1:0]  device;
	logic [rht_pkg::OBJ_W-1:0]  object_number;
	logic [rht_pkg::SLOT_W-1:0] slot;
	logic [rht_pkg::LINK_W-1:0] link_count;

	modport source (output valid, action, device, object_number, slot, link_count,
		input ready);
	modport sink (input valid, action, device, object_number, slot, link_count,
		output ready);
endinterface

// File: sv/rht_rsp_if.sv
// Response channel: slot, status, free-on-disk flag and count after.
interface rht_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rht_pkg::SLOT_W-1:0]   result_slot;
	logic [rht_pkg::STATUS_W-1:0] status;
	logic                         free_on_disk;
	logic [rht_pkg::REF_W-1:0]    ref_after;

	modport source (output valid, result_slot, status, free_on_disk, ref_after,
		input ready);
	modport sink (input valid, result_slot, status, free_on_disk, ref_after,
		output ready);
endinterface

// File: sv/rht_cell.sv
// One table entry plus its stage of the search token row.
module rht_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rht_pkg::CELL_W-1:0]  idx,
	input  rht_pkg::tok_t               tok_in,
	output rht_pkg::tok_t               tok_out,
	input  rht_pkg::wr_t                cmt
);
	import rht_pkg::*;

	logic [DEV_W-1:0]  dev_q;
	logic [OBJ_W-1:0]  obj_q;
	logic [REF_W-1:0]  refs_q;
	logic              valid_q;
	logic [LINK_W-1:0] links_q;
	tok_t              tok_q;
	tok_t              tok_nx;
	logic              live;
	logic              key_eq;
	logic              slot_eq;

	assign live    = (refs_q != '0);
	assign key_eq  = (dev_q == tok_in.dev) && (obj_q == tok_in.obj);
	assign slot_eq = (tok_in.slot == SLOT_W'(idx));

	always_comb begin
		tok_nx = tok_in;
		if (tok_in.act == ACT_GET) begin
			if (!tok_in.hit && live && key_eq) begin
				tok_nx.hit     = 1'b1;
				tok_nx.hit_idx = idx;
				tok_nx.refs    = refs_q;
			end
			if (!tok_in.free && !live) begin
				tok_nx.free     = 1'b1;
				tok_nx.free_idx = idx;
			end
		end else if (slot_eq) begin
			tok_nx.hit     = 1'b1;
			tok_nx.hit_idx = idx;
			tok_nx.refs    = refs_q;
			tok_nx.valid   = valid_q;
			tok_nx.lz      = (links_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q   <= '0;
			obj_q   <= '0;
			refs_q  <= '0;
			valid_q <= 1'b0;
			links_q <= '0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nx;
			if (cmt.en && (cmt.idx == idx)) begin
				refs_q <= cmt.refs;
				if (cmt.wr_key) begin
					dev_q <= cmt.dev;
					obj_q <= cmt.obj;
				end
				if (cmt.wr_valid) begin
					valid_q <= cmt.valid;
				end
				if (cmt.wr_links) begin
					links_q <= cmt.links;
				end
			end
		end
	end

	assign tok_out = tok_q;
endmodule

// File: sv/rht_resolve.sv
// Turns a finished search token into the entry update and the response.
module rht_resolve (
	input  rht_pkg::tok_t fin,
	output rht_pkg::wr_t  cmt,
	output rht_pkg::rsp_t res
);
	import rht_pkg::*;

	logic             sat;
	logic [REF_W-1:0] refs_inc;

	assign sat      = (fin.refs == REF_MAX);
	assign refs_inc = sat ? REF_MAX : (fin.refs + REF_W'(1));

	always_comb begin
		cmt        = '0;
		cmt.idx    = fin.hit_idx;
		res        = '0;
		res.slot   = fin.slot;
		res.status = STS_OK;
		if (fin.act == ACT_GET) begin
			if (fin.hit) begin
				cmt.en     = 1'b1;
				cmt.refs   = refs_inc;
				res.slot   = SLOT_W'(fin.hit_idx);
				res.status = sat ? STS_SATURATED : STS_OK;
				res.refs   = refs_inc;
			end else if (fin.free) begin
				// claim: fresh key, one reference, not yet loaded
				cmt.en       = 1'b1;
				cmt.idx      = fin.free_idx;
				cmt.wr_key   = 1'b1;
				cmt.dev      = fin.dev;
				cmt.obj      = fin.obj;
				cmt.refs     = REF_W'(1);
				cmt.wr_valid = 1'b1;
				cmt.valid    = 1'b0;
				res.slot     = SLOT_W'(fin.free_idx);
				res.status   = STS_CLAIMED;
				res.refs     = REF_W'(1);
			end else begin
				res.slot   = '0;
				res.status = STS_FULL;
			end
		end else if (!fin.hit) begin
			// slot past the last entry
			res.status = STS_FULL;
		end else begin
			case (fin.act)
				ACT_RETAIN: begin
					cmt.en     = 1'b1;
					cmt.refs   = refs_inc;
					res.status = sat ? STS_SATURATED : STS_OK;
					res.refs   = refs_inc;
				end
				ACT_RELEASE: begin
					if (fin.refs == '0) begin
						res.status = STS_UNREF;
					end else begin
						cmt.en   = 1'b1;
						cmt.refs = fin.refs - REF_W'(1);
						res.refs = fin.refs - REF_W'(1);
						if ((fin.refs == REF_W'(1)) && fin.valid && fin.lz) begin
							res.fod      = 1'b1;
							cmt.wr_valid = 1'b1;
							cmt.valid    = 1'b0;
						end
					end
				end
				ACT_LINKS: begin
					cmt.en       = 1'b1;
					cmt.refs     = fin.refs;
					cmt.wr_links = 1'b1;
					cmt.links    = fin.links;
					cmt.wr_valid = 1'b1;
					cmt.valid    = 1'b1;
					res.refs     = fin.refs;
				end
				default: begin
					res.status = STS_FULL;
				end
			endcase
		end
	end
endmodule

// File: sv/refcounted_handle_table.sv
// Top level of the refcounted handle table: cell row, resolve step and response register.
// Fully associative table of NCELL entries (64 by default), each keyed by device and
// object number and holding a reference count, a valid bit and a link count. One request
// is in flight at a time. On acceptance a search token enters the first cell and moves one
// cell per clock down the row; every cell checks its own entry and marks the first live key
// match, the first free entry, or the addressed slot. When the token leaves the last cell it
// is registered, the resolve step builds the response from that copy, and a single broadcast
// write updates the chosen entry in the same cycle the response register loads. Response
// valid follows the token walk along the cell row, the finished-token register and the
// response register; a new request is taken only once the previous response has loaded.
// The response register frees the request side while a finished response waits for its
// transfer; a second response waits in the resolve state until the first is taken.
// Reset clears every entry (all counts zero, every entry free) at once.
`include "refcounted_handle_table_defines.svh"

module refcounted_handle_table (
	input  logic      clk,
	input  logic      arst_n,
	rht_req_if.sink   req,
	rht_rsp_if.source rsp
);
	import rht_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t           state_q;
	tok_t             fin_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	tok_t             toks [NCELL+1];
	logic [NCELL-1:0] tok_vld;
	wr_t              cmt_raw;
	wr_t              cmt;
	rsp_t             res;
	logic             accept;
	logic             load;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	// response register takes a new result once the old one is gone or leaving
	assign load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// token injected at the head of the row
	always_comb begin
		toks[0]       = '0;
		toks[0].vld   = accept;
		toks[0].act   = action_t'(req.action);
		toks[0].dev   = req.device;
		toks[0].obj   = req.object_number;
		toks[0].slot  = req.slot;
		toks[0].links = req.link_count;
	end

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		rht_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (CELL_W'(g)),
			.tok_in  (toks[g]),
			.tok_out (toks[g+1]),
			.cmt     (cmt)
		);
		assign tok_vld[g] = toks[g+1].vld;
	end

	rht_resolve u_resolve (
		.fin (fin_q),
		.cmt (cmt_raw),
		.res (res)
	);

	// entry update fires only together with the response load
	always_comb begin
		cmt    = cmt_raw;
		cmt.en = cmt_raw.en && load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (toks[NCELL].vld) begin
						fin_q   <= toks[NCELL];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_slot  = rsp_q.slot;
	assign rsp.status       = rsp_q.status;
	assign rsp.free_on_disk = rsp_q.fod;
	assign rsp.ref_after    = rsp_q.refs;

	// at most one token anywhere in the row
	`RHT_ASSERT_IMPL(a_one_token, clk, arst_n, 1'b1, $countones(tok_vld) <= 1)
	// token leaves the row only while a search is running
	`RHT_ASSERT_IMPL(a_exit_in_scan, clk, arst_n, toks[NCELL].vld, state_q == ST_SCAN)
	// entry writes coincide with a response load
	`RHT_ASSERT_NEXT(a_cmt_loads, clk, arst_n, cmt.en, rsp_valid_q && (state_q == ST_IDLE))
	// a claimed entry always answers with one reference
	`RHT_ASSERT_IMPL(a_claim_one, clk, arst_n, rsp_valid_q && (rsp_q.status == STS_CLAIMED),
		rsp_q.refs == REF_W'(1))
endmodule
